/* hdl/iouc_pkg.sv */
// shared constants for the iou association cost pipeline
package iouc_pkg;

    // default box coordinate width
    localparam int COORD_BITS_DEF = 16;

    // fixed point format of score, overlap and cost (unsigned q1.16)
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int SCORE_W   = Q_W;
    localparam int COST_W    = Q_W;

    // product of overlap and score
    localparam int PROD_W = Q_W + SCORE_W;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    // one quotient bit per divider stage: the integer bit plus the fraction
    localparam int DIV_STAGES = FRAC_BITS + 1;

    typedef logic [Q_W-1:0] t_q16;

endpackage

/* hdl/iou_cost_pair.sv */
// top level: pipelined iou distance cost of one track/detection box pair
// A pair of boxes with the detection score is taken as one request and gives one cost
// (1.0 - iou, or 1.0 - iou * score when score fusion is on), all in unsigned q1.16 with
// 65536 meaning 1.0. The block is a fully pipelined datapath of 1 edge clamp stage,
// 1 area multiply stage, 1 union stage, 17 restoring divider stages that each settle one
// quotient bit, 1 score multiply stage and the output register; a new request enters on
// every clock while no cost is held at the output. The divider resolves one bit per stage
// over a 2*COORD_BITS+1 bit union. A stall on the output freezes the whole pipeline, so
// o_in_ready follows i_out_ready while a cost is waiting. The fusion enable is sampled
// at the last stage, so it must only be written while no request is in flight.
module iou_cost_pair
    import iouc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // configuration: score fusion enable
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,

    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_track_left,
    input  logic signed [COORD_BITS-1:0]  i_track_top,
    input  logic signed [COORD_BITS-1:0]  i_track_right,
    input  logic signed [COORD_BITS-1:0]  i_track_bottom,
    input  logic signed [COORD_BITS-1:0]  i_det_left,
    input  logic signed [COORD_BITS-1:0]  i_det_top,
    input  logic signed [COORD_BITS-1:0]  i_det_right,
    input  logic signed [COORD_BITS-1:0]  i_det_bottom,
    input  logic [SCORE_W-1:0]            i_det_score,

    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COST_W-1:0]             o_cost
);

    // lengths, areas, union and divider remainder widths
    localparam int LW = COORD_BITS;
    localparam int AW = 2 * LW;
    localparam int UW = AW + 1;
    localparam int RW = UW + 1;

    // clamped length hi - lo, zero when negative
    function automatic logic [LW-1:0] clamp_len(
        input logic [LW-1:0] hi,
        input logic [LW-1:0] lo
    );
        logic [LW:0] d;
        d = {hi[LW-1], hi} - {lo[LW-1], lo};
        clamp_len = d[LW] ? '0 : d[LW-1:0];
    endfunction

    // whole pipeline moves together; it only holds while a cost waits at the output
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // configuration register
    logic r_fuse;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fuse <= 1'b0;
        end else if (i_cfg_we) begin
            r_fuse <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: intersection edges and clamped widths / heights
    // ---------------------------------------------------------------
    logic signed [LW-1:0] ix_lo, ix_hi, iy_lo, iy_hi;
    logic                 r_v1;
    logic [LW-1:0]        r_iw, r_ih, r_tw, r_th, r_dw, r_dh;
    logic [SCORE_W-1:0]   r_sc1;

    always_comb begin
        ix_lo = (i_track_left   > i_det_left)   ? i_track_left   : i_det_left;
        iy_lo = (i_track_top    > i_det_top)    ? i_track_top    : i_det_top;
        ix_hi = (i_track_right  < i_det_right)  ? i_track_right  : i_det_right;
        iy_hi = (i_track_bottom < i_det_bottom) ? i_track_bottom : i_det_bottom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_iw  <= clamp_len(ix_hi, ix_lo);
            r_ih  <= clamp_len(iy_hi, iy_lo);
            r_tw  <= clamp_len(i_track_right, i_track_left);
            r_th  <= clamp_len(i_track_bottom, i_track_top);
            r_dw  <= clamp_len(i_det_right, i_det_left);
            r_dh  <= clamp_len(i_det_bottom, i_det_top);
            r_sc1 <= i_det_score;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: intersection and box areas, three parallel multipliers
    // ---------------------------------------------------------------
    logic               r_v2;
    logic [AW-1:0]      r_int2, r_at2, r_ad2;
    logic [SCORE_W-1:0] r_sc2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_int2 <= AW'(r_iw) * AW'(r_ih);
            r_at2  <= AW'(r_tw) * AW'(r_th);
            r_ad2  <= AW'(r_dw) * AW'(r_dh);
            r_sc2  <= r_sc1;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: union = area_t + area_d - intersection (never below inter)
    // ---------------------------------------------------------------
    logic               r_v3;
    logic [AW-1:0]      r_int3;
    logic [UW-1:0]      r_uni3;
    logic [SCORE_W-1:0] r_sc3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_int3 <= r_int2;
            r_uni3 <= {1'b0, r_at2} + {1'b0, r_ad2} - {1'b0, r_int2};
            r_sc3  <= r_sc2;
        end
    end

    // ---------------------------------------------------------------
    // divider: restoring, one quotient bit per stage, msb (integer bit) first
    // ---------------------------------------------------------------
    logic               r_dv  [DIV_STAGES];
    logic [RW-1:0]      r_rem [DIV_STAGES];
    logic [UW-1:0]      r_uni [DIV_STAGES];
    t_q16               r_q   [DIV_STAGES];
    logic               r_uz  [DIV_STAGES];
    logic [SCORE_W-1:0] r_dsc [DIV_STAGES];

    logic [RW-1:0]      n_rem [DIV_STAGES];
    t_q16               n_q   [DIV_STAGES];

    always_comb begin
        logic [RW-1:0] rem_in;
        logic [UW-1:0] uni_in;
        t_q16          q_in;
        logic          take;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                rem_in = RW'(r_int3);
                uni_in = r_uni3;
                q_in   = '0;
            end else begin
                rem_in = r_rem[k-1] << 1;
                uni_in = r_uni[k-1];
                q_in   = r_q[k-1];
            end
            take     = rem_in >= {1'b0, uni_in};
            n_rem[k] = take ? (rem_in - {1'b0, uni_in}) : rem_in;
            n_q[k]   = {q_in[Q_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_v3;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
            r_uni[0] <= r_uni3;
            r_uz[0]  <= (r_uni3 == '0);
            r_dsc[0] <= r_sc3;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_uni[k] <= r_uni[k-1];
                r_uz[k]  <= r_uz[k-1];
                r_dsc[k] <= r_dsc[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // score multiply stage
    // ---------------------------------------------------------------
    t_q16              ov_div;
    logic              r_vm;
    t_q16              r_ovm;
    logic [PROD_W-1:0] r_prod;

    // empty union gives zero overlap
    assign ov_div = r_uz[DIV_STAGES-1] ? '0 : r_q[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= r_dv[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ovm  <= ov_div;
            r_prod <= PROD_W'(ov_div) * PROD_W'(r_dsc[DIV_STAGES-1]);
        end
    end

    // ---------------------------------------------------------------
    // output register: cost = one - overlap (or fused product, saturating at 0)
    // ---------------------------------------------------------------
    logic [PROD_W-FRAC_BITS-1:0] prod_q;
    logic [COST_W-1:0]           n_cost;
    logic                        r_out_v;
    logic [COST_W-1:0]           r_cost;

    always_comb begin
        prod_q = r_prod[PROD_W-1:FRAC_BITS];
        if (r_fuse) begin
            if (prod_q >= (PROD_W-FRAC_BITS)'(ONE_Q)) begin
                n_cost = '0;
            end else begin
                n_cost = ONE_Q - prod_q[Q_W-1:0];
            end
        end else begin
            n_cost = ONE_Q - r_ovm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cost <= n_cost;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_cost      = r_cost;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // the union never falls below the intersection
    a_inter_le_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ({1'b0, r_int3} <= r_uni3))
        else $error("intersection exceeds union");

    // divider remainder stays below the divisor after the first stage
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[DIV_STAGES-1] && !r_uz[DIV_STAGES-1]) |->
            (r_rem[DIV_STAGES-1] < {1'b0, r_uni[DIV_STAGES-1]}))
        else $error("divider remainder not below union");

    // overlap never exceeds one
    a_ov_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[DIV_STAGES-1] |-> (ov_div <= ONE_Q))
        else $error("overlap above one");

    // a held pipeline keeps its valid bits in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_vm) |=> (r_vm && o_out_valid))
        else $error("request lost during stall");

endmodule

/* tb/tb_iou_cost_pair.sv */
// self-checking testbench for the iou association cost pipeline
`timescale 1ns / 1ps

module tb_iou_cost_pair;
    import iouc_pkg::*;

    localparam int CW         = COORD_BITS_DEF;
    // 22 pipeline stages per the block's own description; margin is added where it is used
    localparam int PIPE_LAT   = 22;
    // longest legal quiet stretch is the long receiver hold (LONG_HOLD), so this is ample
    localparam int STALL_MAX  = 3000;
    localparam int LONG_HOLD  = 300;
    localparam int SHOW_MAX   = 10;

    // one request: a track box, a detection box and the detection score
    typedef struct packed {
        logic [CW-1:0]      track_left;
        logic [CW-1:0]      track_top;
        logic [CW-1:0]      track_right;
        logic [CW-1:0]      track_bottom;
        logic [CW-1:0]      det_left;
        logic [CW-1:0]      det_top;
        logic [CW-1:0]      det_right;
        logic [CW-1:0]      det_bottom;
        logic [SCORE_W-1:0] det_score;
    } t_box_pair;

    // every input starts at a known level
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_ready = 1'b0;
    t_box_pair  in_req      = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_q16       o_cost;

    // requests waiting to be offered, and costs waiting to come back
    t_box_pair  pending[$];
    t_q16       cost_expect[$];

    // mirror of the score fusion register, tracked from the write port
    logic       fuse_cfg      = 1'b0;
    logic       in_taken      = 1'b0;
    int         stall_cycles  = 0;
    int         miss_count    = 0;

    // idling knobs, set per phase by the stimulus process
    logic       tx_idle_en    = 1'b0;
    logic       rx_idle_en    = 1'b0;
    logic       long_hold_req = 1'b0;
    logic       long_hold_done = 1'b0;
    int         tx_gap        = 0;
    int         rx_hold       = 0;

    iou_cost_pair #(
        .COORD_BITS (CW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_track_left   (in_req.track_left),
        .i_track_top    (in_req.track_top),
        .i_track_right  (in_req.track_right),
        .i_track_bottom (in_req.track_bottom),
        .i_det_left     (in_req.det_left),
        .i_det_top      (in_req.det_top),
        .i_det_right    (in_req.det_right),
        .i_det_bottom   (in_req.det_bottom),
        .i_det_score    (in_req.det_score),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cost         (o_cost)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // cost predictor
    // ------------------------------------------------------------------

    // positive part of an edge difference, as a box or overlap extent
    function automatic longint unsigned extent(logic [CW-1:0] hi_e, logic [CW-1:0] lo_e);
        longint d;
        d = longint'($signed(hi_e)) - longint'($signed(lo_e));
        return (d > 0) ? longint'(d) : 0;
    endfunction

    function automatic logic [CW-1:0] smin(logic [CW-1:0] a, logic [CW-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic logic [CW-1:0] smax(logic [CW-1:0] a, logic [CW-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    // 1.0 - iou, or 1.0 - iou * score when fused, all q1.16
    function automatic t_q16 iou_cost(t_box_pair r, logic fuse);
        longint unsigned inter, area_trk, area_det, uni, ovl, prod;
        inter = extent(smin(r.track_right, r.det_right), smax(r.track_left, r.det_left))
              * extent(smin(r.track_bottom, r.det_bottom), smax(r.track_top, r.det_top));
        area_trk = extent(r.track_right, r.track_left) * extent(r.track_bottom, r.track_top);
        area_det = extent(r.det_right, r.det_left) * extent(r.det_bottom, r.det_top);
        uni = area_trk + area_det - inter;
        // intersection never exceeds either area, so the quotient tops out at 1.0
        ovl = (uni == 0) ? 0 : (inter << FRAC_BITS) / uni;
        if (!fuse)
            return t_q16'(longint'(ONE_Q) - ovl);
        prod = (ovl * r.det_score) >> FRAC_BITS;
        // a score above 1.0 can push the product past one: cost floors at zero
        return (prod >= ONE_Q) ? '0 : t_q16'(longint'(ONE_Q) - prod);
    endfunction

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------

    // mostly back to back, now and then a short gap, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_pair(int tl, int tt, int tr, int tb,
                            int dl, int dt, int dr, int db, int score);
        t_box_pair r;
        r.track_left   = CW'(tl);
        r.track_top    = CW'(tt);
        r.track_right  = CW'(tr);
        r.track_bottom = CW'(tb);
        r.det_left     = CW'(dl);
        r.det_top      = CW'(dt);
        r.det_right    = CW'(dr);
        r.det_bottom   = CW'(db);
        r.det_score    = SCORE_W'(score);
        pending.push_back(r);
    endtask

    // mostly overlapping box pairs of modest size, plus full-scale boxes
    // and raw noise that is mostly inverted or disjoint
    task automatic add_random_pair();
        int kind, tl, tt, w, h, dl, dt, dw, dh, score;
        kind = $urandom_range(0, 99);
        score = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
              : ($urandom_range(0, 19) == 0) ? 65536 : $urandom_range(0, 65536);
        if (kind < 15) begin
            add_pair($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 131071));
        end else if (kind < 30) begin
            // boxes that span most of the coordinate range
            tl = -32768 + $urandom_range(0, 100);
            tt = -32768 + $urandom_range(0, 100);
            dl = $urandom_range(0, 65535) - 32768;
            dt = $urandom_range(0, 65535) - 32768;
            add_pair(tl, tt, 32767 - $urandom_range(0, 100), 32767 - $urandom_range(0, 100),
                     dl, dt, dl + $urandom_range(0, 32767 - dl),
                     dt + $urandom_range(0, 32767 - dt), score);
        end else begin
            tl = $urandom_range(0, 52000) - 26000;
            tt = $urandom_range(0, 52000) - 26000;
            w  = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 2000);
            h  = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 2000);
            dl = tl + $urandom_range(0, 2 * w + 2) - w - 1;
            dt = tt + $urandom_range(0, 2 * h + 2) - h - 1;
            dw = $urandom_range(0, 3) == 0 ? w : $urandom_range(0, w + 1);
            dh = $urandom_range(0, 3) == 0 ? h : $urandom_range(0, h + 1);
            add_pair(tl, tt, tl + w, tt + h, dl, dt, dl + dw, dt + dh, score);
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: valid holds with its payload until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap     <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                in_req     <= pending.pop_front();
                i_in_valid <= 1'b1;
                tx_gap     <= tx_idle_en ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side backpressure, with one long hold so the pipeline fills
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            rx_hold        = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_idle_en)
                rx_hold = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each request, compare on each cost
    // ------------------------------------------------------------------
    task automatic report_miss(string what, t_q16 want, t_q16 got);
        miss_count++;
        if (miss_count <= SHOW_MAX)
            $display("%0t: %s: expected cost %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        logic out_fire;
        t_q16 want;
        if (!i_rst_n) begin
            fuse_cfg = 1'b0;
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && o_in_ready;
            out_fire = o_out_valid && i_out_ready;
            if (in_taken)
                cost_expect.push_back(iou_cost(in_req, fuse_cfg));
            if (out_fire) begin
                if (cost_expect.size() == 0) begin
                    report_miss("cost with no request pending", 'x, o_cost);
                end else begin
                    want = cost_expect.pop_front();
                    if (o_cost !== want)
                        report_miss("cost mismatch", want, o_cost);
                end
            end
            // register only changes while the pipeline is empty
            if (i_cfg_we)
                fuse_cfg = i_cfg_wdata;
            stall_cycles = (in_taken || out_fire) ? 0 : stall_cycles + 1;
        end
    end

    // hang detection: too long without any request or cost moving
    initial begin
        @(posedge i_rst_n);
        while (stall_cycles < STALL_MAX)
            @(negedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------

    // sender pauses here until every expected cost is back
    task automatic wait_drained();
        while (pending.size() > 0 || (i_in_valid && !in_taken) || cost_expect.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_fuse(logic v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(logic fuse, logic tx_en, logic rx_en, logic hold, int n);
        write_fuse(fuse);
        @(posedge i_clk);
        tx_idle_en    <= tx_en;
        rx_idle_en    <= rx_en;
        long_hold_req <= hold;
        repeat (n) add_random_pair();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;

        // plain iou cost, register still at its reset value
        add_pair(0, 0, 100, 100, 0, 0, 100, 100, 65536);                  // identical
        add_pair(0, 0, 10, 10, 20, 20, 30, 30, 65536);                    // disjoint
        add_pair(0, 0, 10, 10, 10, 0, 20, 10, 65536);                     // edges touch
        add_pair(0, 0, 10, 10, 5, 5, 15, 15, 0);                          // partial
        add_pair(10, 0, 0, 10, 0, 0, 10, 10, 65536);                      // track inverted
        add_pair(0, 0, 10, 10, 0, 10, 10, 0, 65536);                      // det inverted
        add_pair(5, 5, 5, 5, 5, 5, 5, 5, 65536);                          // empty union
        add_pair(-32768, -32768, 32767, 32767,
                 -32768, -32768, 32767, 32767, 131071);                   // full range
        add_pair(-32768, -32768, 32767, 32767, -1, -1, 1, 1, 65536);      // tiny inside
        add_pair(32766, 32766, 32767, 32767,
                 -32768, -32768, 32767, 32767, 65536);
        add_pair(32767, 32767, -32768, -32768,
                 32767, 32767, -32768, -32768, 65536);                    // worst inversion

        // score fusion on
        write_fuse(1'b1);
        @(posedge i_clk);
        add_pair(0, 0, 100, 100, 0, 0, 100, 100, 131071);                 // saturates to 0
        add_pair(0, 0, 100, 100, 0, 0, 100, 100, 65536);
        add_pair(0, 0, 100, 100, 0, 0, 100, 100, 0);
        add_pair(0, 0, 10, 10, 5, 5, 15, 15, 100000);                     // score above one
        add_pair(0, 0, 10, 10, 5, 5, 15, 15, 32768);
        add_pair(-32768, -32768, 32767, 32767,
                 -32768, -32768, 32767, 32767, 1);
        add_pair(3, 3, 3, 3, 3, 3, 3, 3, 131071);                         // empty union
        add_pair(0, 0, 1, 1, 0, 0, 2, 2, 131071);

        // random phases: idling, a no-idle stretch, one long receiver hold
        random_phase(1'b0, 1'b1, 1'b1, 1'b0, 400);
        random_phase(1'b1, 1'b0, 1'b0, 1'b0, 300);
        random_phase(1'b1, 1'b0, 1'b1, 1'b1, 300);  // sender keeps offering during the hold
        random_phase(1'b0, 1'b0, 1'b1, 1'b0, 300);
        random_phase(1'b1, 1'b1, 1'b0, 1'b0, 400);

        wait_drained();
        repeat (PIPE_LAT + 8) @(negedge i_clk);
        miss_count += cost_expect.size();
        if (miss_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
